// ===== rtl/core/max_window_sum_integral_image_unit_macros.svh =====
// Assertion macros for the checker of the max window sum unit.
// Needs nothing else; included by bare file name.
`ifndef MAX_WINDOW_SUM_INTEGRAL_IMAGE_UNIT_MACROS_SVH
`define MAX_WINDOW_SUM_INTEGRAL_IMAGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWSII_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwsii check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWSII_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwsii check failed");

`endif

// ===== rtl/core/mwsii_pkg.sv =====
// Shared constants for the max window sum (summed-area table) unit.
// No dependencies; imported by the top level and its checker.
package mwsii_pkg;

    localparam int REG_W            = 11;
    localparam int NUM_REGS         = 4;
    localparam int REG_IDX_W        = $clog2(NUM_REGS);

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_ROWS   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_COLS   = 2'd3;

    localparam int APB_AW           = REG_IDX_W + 2;
    localparam int APB_DW           = 32;

    localparam int OUT_SUM_W        = 36;
    localparam int M_TDATA_W        = ((OUT_SUM_W + 7) / 8) * 8;

    localparam int MAX_ROWS_DEF     = 1024;
    localparam int MAX_COLS_DEF     = 1024;
    localparam int ELEMENT_BITS_DEF = 16;

endpackage

// ===== rtl/core/mwsii_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mwsii_ram #(
    parameter int  WIDTH = 36,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/max_window_sum_integral_image_unit.sv =====
// Top level of the max window sum unit: summed-area table in one RAM, box sums.
// Depends on mwsii_pkg and mwsii_ram.
//
// Usage:
//   Program image_rows, image_cols, win_rows, win_cols over the APB port
//   (byte addresses 0, 4, 8, 12) while the unit is idle; any write restarts
//   the matrix. Stream elements in raster order on s_axis (tdata[15:0]).
//   After the last element of each matrix one result transaction appears on
//   m_axis: tdata holds the largest box sum, tuser flags a window larger
//   than the image (sum is then zero).
// Pacing: the RAM read port sets the element rate; it serves four prefix
//   reads per element, one per step (above, diagonal corner, upper corner,
//   left corner); the write goes through the separate write port.
//   A one-entry input buffer takes the next element while one is in work.
// Result path: input buffer, up/diag/above/left steps, tail register, output register.
// Reset: registers return to 1x1 image and window, position and best sum to
//   zero. The table RAM is not cleared; no cell's value is used before it is written.
// Stall: a held result stays in the output register; elements keep flowing
//   until the following matrix end, which then waits for the receiver.
module max_window_sum_integral_image_unit #(
    parameter int  MAX_ROWS     = mwsii_pkg::MAX_ROWS_DEF,
    parameter int  MAX_COLS     = mwsii_pkg::MAX_COLS_DEF,
    parameter int  ELEMENT_BITS = mwsii_pkg::ELEMENT_BITS_DEF,
    localparam int S_TDATA_W    = ((ELEMENT_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mwsii_pkg::APB_AW-1:0]    paddr,
    input  logic [mwsii_pkg::APB_DW-1:0]    pwdata,
    output logic [mwsii_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    // element input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,   // [ELEMENT_BITS-1:0] element
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mwsii_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [35:0] max_sum
    output logic                            m_axis_tuser    // [0] no_window
);
    import mwsii_pkg::*;

    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RDIM_W  = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W  = $clog2(MAX_COLS + 1);
    localparam int DMAX_W  = (RDIM_W > CDIM_W) ? RDIM_W : CDIM_W;
    localparam int DIM_W   = ((DMAX_W > REG_W) ? DMAX_W : REG_W) + 1;
    localparam int RS_W    = ELEMENT_BITS + CW;
    localparam int SUM_W   = ELEMENT_BITS + RW + CW;
    localparam int ACC_W   = SUM_W + 1;
    localparam int MEM_DEPTH = MAX_ROWS * (2 ** CW);
    localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [1:0] STEP_UP    = 2'd0;
    localparam logic [1:0] STEP_DIAG  = 2'd1;
    localparam logic [1:0] STEP_ABOVE = 2'd2;
    localparam logic [1:0] STEP_LEFT  = 2'd3;

    typedef struct packed {
        logic valid;
        logic fit;
        logic nofit;
        logic last;
        logic left_zero;
    } t_tail;

    // configuration
    logic [REG_W-1:0] r_image_rows, r_image_cols, r_win_rows, r_win_cols;
    logic             cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // pipeline state
    logic                    r_in_valid;
    logic [ELEMENT_BITS-1:0] r_in_elem;
    logic                    r_busy;
    logic [1:0]              r_step;
    logic [ELEMENT_BITS-1:0] r_elem;
    logic [RW-1:0]           r_row;
    logic [CW-1:0]           r_col;
    logic [RS_W-1:0]         r_rowsum;
    logic [SUM_W-1:0]        r_p;
    logic [ACC_W-1:0]        r_acc;
    t_tail                   r_tail, n_tail;
    logic [SUM_W-1:0]        r_best;
    logic                    r_out_valid;
    logic [OUT_SUM_W-1:0]    r_out_sum;
    logic                    r_out_nowin;

    // derived
    logic [DIM_W-1:0] rows_eff, cols_eff, wr_eff, wc_eff, row_ext, col_ext;
    logic [DIM_W-1:0] rdiff, cdiff;
    logic             no_fit, fit_now, r0_neg, c0_neg, col_last, row_last;
    logic [RW-1:0]    r0, row_up;
    logic [CW-1:0]    c0;
    logic             stall, take, step_go, out_load;
    logic             mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [SUM_W-1:0] mem_rdata;
    logic [ACC_W-1:0] box;
    logic [SUM_W-1:0] box_s, best_upd;
    logic [OUT_SUM_W-1:0] sum_sat;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_ROWS: prdata = APB_DW'(r_image_rows);
            REG_IMAGE_COLS: prdata = APB_DW'(r_image_cols);
            REG_WIN_ROWS:   prdata = APB_DW'(r_win_rows);
            REG_WIN_COLS:   prdata = APB_DW'(r_win_cols);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= REG_W'(1);
            r_image_cols <= REG_W'(1);
            r_win_rows   <= REG_W'(1);
            r_win_cols   <= REG_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_ROWS: r_image_rows <= pwdata[REG_W-1:0];
                REG_IMAGE_COLS: r_image_cols <= pwdata[REG_W-1:0];
                REG_WIN_ROWS:   r_win_rows   <= pwdata[REG_W-1:0];
                REG_WIN_COLS:   r_win_cols   <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one; image clamps to the table size
    always_comb begin
        if (r_image_rows == '0) begin
            rows_eff = DIM_W'(1);
        end else if (DIM_W'(r_image_rows) > DIM_W'(MAX_ROWS)) begin
            rows_eff = DIM_W'(MAX_ROWS);
        end else begin
            rows_eff = DIM_W'(r_image_rows);
        end
        if (r_image_cols == '0) begin
            cols_eff = DIM_W'(1);
        end else if (DIM_W'(r_image_cols) > DIM_W'(MAX_COLS)) begin
            cols_eff = DIM_W'(MAX_COLS);
        end else begin
            cols_eff = DIM_W'(r_image_cols);
        end
        wr_eff = (r_win_rows == '0) ? DIM_W'(1) : DIM_W'(r_win_rows);
        wc_eff = (r_win_cols == '0) ? DIM_W'(1) : DIM_W'(r_win_cols);
    end

    assign no_fit   = (wr_eff > rows_eff) || (wc_eff > cols_eff);
    assign row_ext  = DIM_W'(r_row);
    assign col_ext  = DIM_W'(r_col);
    assign rdiff    = row_ext - wr_eff;
    assign cdiff    = col_ext - wc_eff;
    assign r0_neg   = rdiff[DIM_W-1];
    assign c0_neg   = cdiff[DIM_W-1];
    assign r0       = rdiff[RW-1:0];
    assign c0       = cdiff[CW-1:0];
    assign row_up   = r_row - RW'(1);
    assign fit_now  = !no_fit && (row_ext + DIM_W'(1) >= wr_eff)
                      && (col_ext + DIM_W'(1) >= wc_eff);
    assign col_last = (col_ext + DIM_W'(1) >= cols_eff);
    assign row_last = (row_ext + DIM_W'(1) >= rows_eff);

    // tail holds when a matrix end meets a full output register
    assign stall    = r_tail.valid && r_tail.last && r_out_valid && !m_axis_tready;
    assign take     = r_in_valid && !stall && (!r_busy || (r_step == STEP_LEFT));
    assign step_go  = r_busy && !stall;
    assign out_load = r_tail.valid && r_tail.last && !stall;

    assign s_axis_tready = !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_elem <= s_axis_tdata[ELEMENT_BITS-1:0];
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_UP;
        end else if (take) begin
            r_busy <= 1'b1;
            r_step <= STEP_UP;
        end else if (step_go) begin
            if (r_step == STEP_LEFT) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_elem <= r_in_elem;
        end
    end

    // position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (step_go && r_step == STEP_LEFT) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // read address per step; write of the new prefix in the third step
    always_comb begin
        case (r_step)
            STEP_UP:    mem_raddr = MEM_AW'({row_up, r_col});
            STEP_DIAG:  mem_raddr = MEM_AW'({r0, c0});
            STEP_ABOVE: mem_raddr = MEM_AW'({r0, r_col});
            STEP_LEFT:  mem_raddr = MEM_AW'({r_row, c0});
            default:    mem_raddr = '0;
        endcase
    end

    assign mem_re    = step_go;
    assign mem_we    = step_go && (r_step == STEP_ABOVE);
    assign mem_waddr = MEM_AW'({r_row, r_col});

    mwsii_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MEM_DEPTH)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_p),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // read-modify: row sum, prefix, box accumulation
    always_ff @(posedge i_clk) begin
        if (step_go) begin
            case (r_step)
                STEP_UP: begin
                    r_rowsum <= ((r_col == '0) ? RS_W'(0) : r_rowsum) + RS_W'(r_elem);
                end
                STEP_DIAG: begin
                    r_p <= ((r_row == '0) ? SUM_W'(0) : mem_rdata) + SUM_W'(r_rowsum);
                end
                STEP_ABOVE: begin
                    r_acc <= ACC_W'(r_p)
                             + ((r0_neg || c0_neg) ? ACC_W'(0) : ACC_W'(mem_rdata));
                end
                STEP_LEFT: begin
                    r_acc <= r_acc - (r0_neg ? ACC_W'(0) : ACC_W'(mem_rdata));
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tail           = r_tail;
        n_tail.valid     = step_go && (r_step == STEP_LEFT);
        n_tail.fit       = fit_now;
        n_tail.nofit     = no_fit;
        n_tail.last      = col_last && row_last;
        n_tail.left_zero = c0_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
        end else if (!stall) begin
            r_tail <= n_tail;
        end
    end

    // tail: last corner, running maximum, result
    assign box      = r_acc - (r_tail.left_zero ? ACC_W'(0) : ACC_W'(mem_rdata));
    assign box_s    = box[SUM_W-1:0];
    assign best_upd = (r_tail.fit && box_s > r_best) ? box_s : r_best;
    assign sum_sat  = ((best_upd >> OUT_SUM_W) != '0) ? '1 : OUT_SUM_W'(best_upd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_best <= '0;
        end else if (r_tail.valid && !stall) begin
            r_best <= r_tail.last ? '0 : best_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sum   <= r_tail.nofit ? '0 : sum_sat;
            r_out_nowin <= r_tail.nofit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_sum);
    assign m_axis_tuser  = r_out_nowin;

endmodule

// ===== rtl/core/mwsii_checker.sv =====
// Port-level checker for the max window sum unit, with its bind statement.
// Depends on mwsii_pkg and max_window_sum_integral_image_unit_macros.svh.
`include "max_window_sum_integral_image_unit_macros.svh"

module mwsii_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mwsii_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [35:0] max_sum
    input logic                            m_axis_tuser    // [0] no_window
);
    import mwsii_pkg::*;

    // a window that does not fit reports a zero sum
    `MWSII_ASSERT_IMP(a_nowin_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

    // a stalled result holds
    `MWSII_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one-entry input buffer: a transaction always fills it
    `MWSII_ASSERT_NXT(a_in_buffer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind max_window_sum_integral_image_unit mwsii_checker u_mwsii_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
